// ===== rtl/pcrc_pkg.sv =====
// Package for the page store with per-block CRC-16.
// Holds the item structs, op and state codes, defaults and the CRC byte step.
// No dependencies.
package pcrc_pkg;

   // Default geometry of the store.
   localparam int PAGE_BYTES_DEF  = 1024;
   localparam int BLOCK_BYTES_DEF = 256;
   localparam int PAGES_DEF       = 8;

   // Field widths of the item, fixed by the interface.
   localparam int PAGE_W   = 3;
   localparam int OFFSET_W = 10;
   localparam int BLOCK_W  = 5;
   localparam int PAGE_CODES = 2 ** PAGE_W;

   // CRC-16 polynomial, unreflected, zero initial value.
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef enum logic [2:0] {
      OP_WRITE   = 3'd0,
      OP_SEAL    = 3'd1,
      OP_CLEAR   = 3'd2,
      OP_RD_CRC  = 3'd3,
      OP_RD_BYTE = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SEAL,
      ST_CLEAR,
      ST_DRAIN,
      ST_RDWAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]          op;
      logic [PAGE_W-1:0]   page;
      logic [OFFSET_W-1:0] offset;
      logic [7:0]          data;
      logic [BLOCK_W-1:0]  block;
   } req_type;

   typedef struct packed {
      logic [15:0] crc_value;
      logic [7:0]  read_byte;
      logic        changed;
   } rsp_type;

   // Result handed from the controller to the output stage.
   typedef struct packed {
      logic    valid;
      rsp_type item;
   } res_type;

   // Folds one byte into the CRC, most significant bit first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/page_store_with_block_crc.sv =====
// Top level of the page store with per-block CRC-16.
// Instantiates pcrc_ctrl and two pcrc_ram memories and holds the output register.
// Depends on pcrc_pkg.
//
// Usage:
//   req_* carries one operation item (write byte, seal page, clear page,
//   read block CRC, read byte); rsp_* returns exactly one result item for
//   each request, in order. Both channels use valid/ready.
//   Byte writes and unused op codes answer in the cycle after they are accepted, and a stream of
//   byte writes is taken at one item per cycle while rsp_ready stays high.
//   Byte and CRC reads pass from accept to rsp_valid through the memory
//   read, a capture register and the output register.
//   Seal reads the page's whole blocks one byte a cycle through the byte
//   memory port.
//   Clear zeroes one byte a cycle through the same memory.
//   After reset the block sweeps both memories to zero, with req_ready low.
//   When rsp_ready is low the result waits in the output register and
//   req_ready stays low until it is taken; a result that finishes meanwhile
//   waits in the controller until the register empties.
module page_store_with_block_crc #(
   parameter int PAGE_BYTES  = pcrc_pkg::PAGE_BYTES_DEF,
   parameter int BLOCK_BYTES = pcrc_pkg::BLOCK_BYTES_DEF,
   parameter int PAGES       = pcrc_pkg::PAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pcrc_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcrc_pkg::rsp_type rsp_item
);
   import pcrc_pkg::*;

   localparam int TOTAL    = PAGES * PAGE_BYTES;
   localparam int NBLOCKS  = TOTAL / BLOCK_BYTES;
   localparam int NBLK_MEM = (NBLOCKS > 0) ? NBLOCKS : 1;
   localparam int ADDR_W   = $clog2(TOTAL);
   localparam int CADDR_W  = (NBLK_MEM > 1) ? $clog2(NBLK_MEM) : 1;

   logic               slot_free;
   res_type            res;
   logic               byte_we;
   logic [ADDR_W-1:0]  byte_waddr;
   logic [7:0]         byte_wdata;
   logic               byte_re;
   logic [ADDR_W-1:0]  byte_raddr;
   logic [7:0]         byte_rdata;
   logic               crc_we;
   logic [CADDR_W-1:0] crc_waddr;
   logic [15:0]        crc_wdata;
   logic               crc_re;
   logic [CADDR_W-1:0] crc_raddr;
   logic [15:0]        crc_rdata;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_item_ff, rsp_item_in;

   pcrc_ctrl #(
      .PAGE_BYTES  (PAGE_BYTES),
      .BLOCK_BYTES (BLOCK_BYTES),
      .PAGES       (PAGES),
      .ADDR_W      (ADDR_W),
      .CADDR_W     (CADDR_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .slot_free  (slot_free),
      .res        (res),
      .byte_we    (byte_we),
      .byte_waddr (byte_waddr),
      .byte_wdata (byte_wdata),
      .byte_re    (byte_re),
      .byte_raddr (byte_raddr),
      .byte_rdata (byte_rdata),
      .crc_we     (crc_we),
      .crc_waddr  (crc_waddr),
      .crc_wdata  (crc_wdata),
      .crc_re     (crc_re),
      .crc_raddr  (crc_raddr),
      .crc_rdata  (crc_rdata)
   );

   // Page bytes, all pages back to back.
   pcrc_ram #(
      .WIDTH (8),
      .DEPTH (TOTAL),
      .AW    (ADDR_W)
   ) u_byte_ram (
      .clock (clock),
      .we    (byte_we),
      .waddr (byte_waddr),
      .wdata (byte_wdata),
      .re    (byte_re),
      .raddr (byte_raddr),
      .rdata (byte_rdata)
   );

   // Stored block CRCs.
   pcrc_ram #(
      .WIDTH (16),
      .DEPTH (NBLK_MEM),
      .AW    (CADDR_W)
   ) u_crc_ram (
      .clock (clock),
      .we    (crc_we),
      .waddr (crc_waddr),
      .wdata (crc_wdata),
      .re    (crc_re),
      .raddr (crc_raddr),
      .rdata (crc_rdata)
   );

   // Output register: takes a new result when empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = res.item;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== rtl/pcrc_ram.sv =====
// Simple dual-port synchronous memory: one write port, one read port.
// Read data is registered. No package dependency.
module pcrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/pcrc_ctrl.sv =====
// Sequencer of the page store: init sweep, byte access, seal and clear walks.
// Drives both memories and hands results to the output stage. Uses pcrc_pkg.
module pcrc_ctrl #(
   parameter int PAGE_BYTES  = pcrc_pkg::PAGE_BYTES_DEF,
   parameter int BLOCK_BYTES = pcrc_pkg::BLOCK_BYTES_DEF,
   parameter int PAGES       = pcrc_pkg::PAGES_DEF,
   parameter int ADDR_W      = $clog2(PAGES * PAGE_BYTES),
   parameter int CADDR_W     = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  pcrc_pkg::req_type        req_item,
   input  logic                     slot_free,
   output pcrc_pkg::res_type        res,
   output logic                     byte_we,
   output logic [ADDR_W-1:0]        byte_waddr,
   output logic [7:0]               byte_wdata,
   output logic                     byte_re,
   output logic [ADDR_W-1:0]        byte_raddr,
   input  logic [7:0]               byte_rdata,
   output logic                     crc_we,
   output logic [CADDR_W-1:0]       crc_waddr,
   output logic [15:0]              crc_wdata,
   output logic                     crc_re,
   output logic [CADDR_W-1:0]       crc_raddr,
   input  logic [15:0]              crc_rdata
);
   import pcrc_pkg::*;

   localparam int TOTAL      = PAGES * PAGE_BYTES;
   localparam int NBLOCKS    = TOTAL / BLOCK_BYTES;
   localparam int COUNT      = PAGE_BYTES / BLOCK_BYTES;
   localparam int SEAL_BYTES = COUNT * BLOCK_BYTES;
   localparam int BIB_W      = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam logic [ADDR_W:0] NBLK_L  = (ADDR_W + 1)'(NBLOCKS);
   localparam logic [ADDR_W:0] COUNT_L = (ADDR_W + 1)'(COUNT);

   // Per page code: byte base, first block and the byte where its first block starts.
   logic [ADDR_W-1:0]  base_tbl  [PAGE_CODES];
   logic [CADDR_W-1:0] first_tbl [PAGE_CODES];
   logic [ADDR_W-1:0]  start_tbl [PAGE_CODES];

   for (genvar p = 0; p < PAGE_CODES; p++) begin : g_tbl
      localparam int BASE  = p * PAGE_BYTES;
      localparam int FIRST = BASE / BLOCK_BYTES;
      localparam int START = FIRST * BLOCK_BYTES;
      assign base_tbl[p]  = ADDR_W'(BASE);
      assign first_tbl[p] = CADDR_W'(FIRST);
      assign start_tbl[p] = ADDR_W'(START);
   end

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [CADDR_W-1:0] blk_ff, blk_in;
   logic [BIB_W-1:0]   bib_ff, bib_in;
   logic [15:0]        crc_ff, crc_in;
   logic               changed_ff, changed_in;
   rsp_type            res_ff, res_in;
   logic               rd_byte_ff, rd_byte_in;
   logic               rd_crc_ff, rd_crc_in;
   logic               fold_vld_ff, fold_vld_in;
   logic               fold_last_ff, fold_last_in;
   logic [CADDR_W-1:0] fold_blk_ff, fold_blk_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [CADDR_W-1:0] chk_addr_ff, chk_addr_in;

   logic [15:0]        crc_next;
   logic               page_ok;
   logic               off_ok;
   logic               blk_ok;
   logic [ADDR_W-1:0]  item_addr;

   // Range checks and the byte address of the incoming item.
   assign page_ok   = int'(req_item.page) < PAGES;
   assign off_ok    = int'(req_item.offset) < PAGE_BYTES;
   assign blk_ok    = int'(req_item.block) < NBLOCKS;
   assign item_addr = base_tbl[req_item.page] + ADDR_W'(req_item.offset);

   // One byte of the running seal CRC, from the byte read in the previous cycle.
   assign crc_next = crc_byte(crc_ff, byte_rdata);

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         fold_vld_ff  <= 1'b0;
         fold_last_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         changed_ff   <= 1'b0;
         rd_byte_ff   <= 1'b0;
         rd_crc_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fold_vld_ff  <= fold_vld_in;
         fold_last_ff <= fold_last_in;
         chk_vld_ff   <= chk_vld_in;
         changed_ff   <= changed_in;
         rd_byte_ff   <= rd_byte_in;
         rd_crc_ff    <= rd_crc_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      blk_ff      <= blk_in;
      bib_ff      <= bib_in;
      crc_ff      <= crc_in;
      res_ff      <= res_in;
      fold_blk_ff <= fold_blk_in;
      chk_addr_ff <= chk_addr_in;
   end

   // Next state, memory commands and results.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      blk_in       = blk_ff;
      bib_in       = bib_ff;
      crc_in       = crc_ff;
      changed_in   = changed_ff;
      res_in       = res_ff;
      rd_byte_in   = rd_byte_ff;
      rd_crc_in    = rd_crc_ff;
      fold_vld_in  = 1'b0;
      fold_last_in = 1'b0;
      fold_blk_in  = fold_blk_ff;
      chk_vld_in   = 1'b0;
      chk_addr_in  = chk_addr_ff;
      req_ready    = 1'b0;
      res          = '0;
      byte_we      = 1'b0;
      byte_waddr   = addr_ff;
      byte_wdata   = '0;
      byte_re      = 1'b0;
      byte_raddr   = addr_ff;
      crc_we       = 1'b0;
      crc_waddr    = chk_addr_ff;
      crc_wdata    = '0;
      crc_re       = 1'b0;
      crc_raddr    = blk_ff;

      // Seal: fold the byte that arrived; at the end of a block store its CRC.
      if (fold_vld_ff) begin
         crc_in = crc_next;
         if (fold_last_ff) begin
            crc_we    = 1'b1;
            crc_waddr = fold_blk_ff;
            crc_wdata = crc_next;
            crc_in    = '0;
         end
      end

      // Clear: note a nonzero stored CRC and zero it. The read of the next
      // block never hits the entry written here, so no forwarding is needed.
      if (chk_vld_ff) begin
         crc_we    = 1'b1;
         crc_waddr = chk_addr_ff;
         crc_wdata = '0;
         if (crc_rdata != '0) begin
            changed_in = 1'b1;
         end
      end

      case (state_ff)
         ST_INIT: begin
            // Zero both memories, one address a cycle.
            byte_we    = 1'b1;
            byte_waddr = cnt_ff;
            crc_we     = ({1'b0, cnt_ff} < NBLK_L);
            crc_waddr  = CADDR_W'(cnt_ff);
            cnt_in     = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(TOTAL - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = slot_free;
            if (req_valid && slot_free) begin
               changed_in = 1'b0;
               cnt_in     = '0;
               crc_in     = '0;
               case (req_item.op)
                  OP_WRITE: begin
                     byte_we    = page_ok && off_ok;
                     byte_waddr = item_addr;
                     byte_wdata = req_item.data;
                     res.valid  = 1'b1;
                  end
                  OP_SEAL: begin
                     if (page_ok && (COUNT > 0)) begin
                        addr_in  = start_tbl[req_item.page];
                        blk_in   = first_tbl[req_item.page];
                        bib_in   = '0;
                        state_in = ST_SEAL;
                     end else begin
                        res.valid = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     if (page_ok) begin
                        addr_in  = base_tbl[req_item.page];
                        blk_in   = first_tbl[req_item.page];
                        state_in = ST_CLEAR;
                     end else begin
                        res.valid = 1'b1;
                     end
                  end
                  OP_RD_CRC: begin
                     crc_re     = blk_ok;
                     crc_raddr  = CADDR_W'(req_item.block);
                     rd_crc_in  = blk_ok;
                     rd_byte_in = 1'b0;
                     state_in   = ST_RDWAIT;
                  end
                  OP_RD_BYTE: begin
                     byte_re    = page_ok && off_ok;
                     byte_raddr = item_addr;
                     rd_byte_in = page_ok && off_ok;
                     rd_crc_in  = 1'b0;
                     state_in   = ST_RDWAIT;
                  end
                  default: begin
                     res.valid = 1'b1;
                  end
               endcase
            end
         end
         ST_SEAL: begin
            // Stream the page's whole blocks out of the byte memory.
            byte_re      = 1'b1;
            byte_raddr   = addr_ff;
            fold_vld_in  = 1'b1;
            fold_last_in = (bib_ff == BIB_W'(BLOCK_BYTES - 1));
            fold_blk_in  = blk_ff;
            addr_in      = addr_ff + ADDR_W'(1);
            cnt_in       = cnt_ff + ADDR_W'(1);
            if (fold_last_in) begin
               bib_in = '0;
               blk_in = blk_ff + CADDR_W'(1);
            end else begin
               bib_in = bib_ff + BIB_W'(1);
            end
            if (cnt_ff == ADDR_W'(SEAL_BYTES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_CLEAR: begin
            // Zero one byte a cycle; check the page's blocks alongside.
            byte_we    = 1'b1;
            byte_waddr = addr_ff;
            byte_wdata = '0;
            if ({1'b0, cnt_ff} < COUNT_L) begin
               crc_re      = 1'b1;
               crc_raddr   = blk_ff;
               chk_vld_in  = 1'b1;
               chk_addr_in = blk_ff;
               blk_in      = blk_ff + CADDR_W'(1);
            end
            addr_in = addr_ff + ADDR_W'(1);
            cnt_in  = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(PAGE_BYTES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last fold or check completes no later than this cycle.
            res_in   = '0;
            state_in = ST_DONE;
         end
         ST_RDWAIT: begin
            res_in.crc_value = rd_crc_ff ? crc_rdata : '0;
            res_in.read_byte = rd_byte_ff ? byte_rdata : '0;
            res_in.changed   = 1'b0;
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            res.valid        = slot_free;
            res.item         = res_ff;
            res.item.changed = changed_ff;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // A result is only handed over when the output stage can hold it.
   a_res_fits: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> slot_free)
      else $error("result offered while output stage is full");

   // Seal and clear pipelines never run together (one CRC write port).
   a_one_walk: assert property (@(posedge clock) disable iff (reset)
      !(fold_vld_ff && chk_vld_ff))
      else $error("seal fold and clear check overlap");

   // The final byte of a seal always closes a block.
   a_seal_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && fold_vld_ff) |-> fold_last_ff)
      else $error("seal ended inside a block");

   // No memory work is left pending once a result is ready.
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!fold_vld_ff && !chk_vld_ff))
      else $error("result ready with work in flight");

endmodule
